// ===== rtl/wacs_pkg.sv =====
package wacs_pkg;

	localparam int MAX_ELEMS  = 32;
	localparam int MAX_WINDOW = 64;
	localparam int ELEM_W     = $clog2(MAX_ELEMS);
	localparam int SLOT_W     = $clog2(MAX_WINDOW);
	localparam int ADDR_W     = ELEM_W + SLOT_W;
	localparam int STORE_DEPTH = MAX_WINDOW * MAX_ELEMS;

	typedef logic [1:0]  cfg_idx_t;
	typedef logic [15:0] cfg_data_t;

	localparam cfg_idx_t CFG_REL_EPSILON = 2'd0;
	localparam cfg_idx_t CFG_WINDOW_LEN  = 2'd1;
	localparam cfg_idx_t CFG_VECTOR_LEN  = 2'd2;

	localparam logic [15:0] RST_REL_EPSILON = 16'd66;
	localparam logic [6:0]  RST_WINDOW_LEN  = 7'd16;
	localparam logic [5:0]  RST_VECTOR_LEN  = 6'd1;

	localparam logic [5:0] DIV_STEPS = 6'd33;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_READ,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               start;
		logic signed [32:0] dividend;
		logic [6:0]         divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [32:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/wacs_ifs.sv =====
interface wacs_smp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_value;
	logic               last_element;
	modport source (output valid, sample_value, last_element, input ready);
	modport sink (input valid, sample_value, last_element, output ready);
endinterface

interface wacs_res_if;
	logic valid;
	logic ready;
	logic converged;
	logic window_full;
	logic length_error;
	modport source (output valid, converged, window_full, length_error, input ready);
	modport sink (input valid, converged, window_full, length_error, output ready);
endinterface

interface wacs_cfg_if;
	logic                valid;
	logic                ready;
	wacs_pkg::cfg_idx_t  index;
	wacs_pkg::cfg_data_t data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/windowed_average_convergence_stop_top.sv =====
// channel  dir   payload                                   handshake
// smp      in    sample_value[31:0] s, last_element         valid/ready
// res      out   converged, window_full, length_error       valid/ready
// cfg      in    index[1:0], data[15:0]                     valid/ready (ready always)
//
// A non-last element is accepted while idle. The last element of a V-element vector
// tests each element when the window is full and, unless that converges, updates the
// average of each element, using the shared 33-step serial divider (one element at a time).
// Reset clears all control state; the window store and averages are not cleared.
// A stalled result holds the block once the next vector's last item is done; no item
// enters until the result is taken.
module windowed_average_convergence_stop_top (
	input logic       clk,
	input logic       arst_n,
	wacs_smp_if.sink  smp,
	wacs_res_if.source res,
	wacs_cfg_if.sink  cfg
);
	import wacs_pkg::*;

	logic [15:0] rel_epsilon_q;
	logic [6:0]  window_len_q;
	logic [5:0]  vector_len_q;
	logic [6:0]  r_eff;
	logic [5:0]  vl_eff;

	logic signed [31:0] avg_q    [MAX_ELEMS];
	logic signed [31:0] staged_q [MAX_ELEMS];
	logic signed [31:0] store_mem [STORE_DEPTH];
	logic signed [31:0] rd_data_q;

	logic [6:0]        fill_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [5:0]        cnt_q;
	logic              first_q, any_q, stopped_q, slide_q;
	logic [ELEM_W-1:0] e_q;
	state_t            st_q, st_d;

	logic pend_conv_q, pend_full_q, pend_len_q;
	logic res_valid_q, res_conv_q, res_full_q, res_len_q;

	logic        acc, last_acc, cfg_acc;
	logic [5:0]  cnt_inc;
	logic        lenerr_now, full_now, e_last;
	logic signed [31:0] avg_e, stg_e;
	logic signed [32:0] diff;
	logic [32:0] d_mag, s_mag;
	logic [48:0] lhs, rhs;
	logic        ok_e;
	logic        in_ready, div_start, commit, load_out;
	logic [ADDR_W-1:0] addr;
	logic signed [33:0] sum;
	logic signed [31:0] avg_new;
	div_req_t    dreq;
	div_rsp_t    drsp;

	assign r_eff  = (window_len_q > 7'(MAX_WINDOW)) ? 7'(MAX_WINDOW) : window_len_q;
	assign vl_eff = (vector_len_q == 6'd0) ? 6'd1 :
		((vector_len_q > 6'(MAX_ELEMS)) ? 6'(MAX_ELEMS) : vector_len_q);

	assign acc      = smp.valid && in_ready;
	assign last_acc = acc && smp.last_element && !stopped_q;
	assign cfg_acc  = cfg.valid;
	assign cfg.ready = 1'b1;
	assign smp.ready = in_ready;

	assign cnt_inc    = (cnt_q <= 6'(MAX_ELEMS)) ? cnt_q + 6'd1 : cnt_q;
	assign lenerr_now = cnt_inc != vl_eff;
	assign full_now   = (r_eff != 7'd0) && (fill_q >= r_eff);
	assign e_last     = ({1'b0, e_q} == (vl_eff - 6'd1));

	assign avg_e = avg_q[e_q];
	assign stg_e = staged_q[e_q];

	// relative test: |a-n|*2^16 < eps*(|a|+|n|)
	assign diff  = 33'(avg_e) - 33'(stg_e);
	assign d_mag = diff[32] ? 33'(-diff) : 33'(diff);
	assign s_mag = (avg_e[31] ? 33'(-33'(avg_e)) : 33'(avg_e))
		+ (stg_e[31] ? 33'(-33'(stg_e)) : 33'(stg_e));
	assign lhs  = {d_mag, 16'd0};
	assign rhs  = 49'(rel_epsilon_q) * 49'(s_mag);
	assign ok_e = ((d_mag == 33'd0) && (s_mag == 33'd0)) || (lhs < rhs);

	assign addr = {(slide_q ? oldest_q : fill_q[SLOT_W-1:0]), e_q};

	assign dreq.start    = div_start;
	assign dreq.dividend = slide_q ? 33'(stg_e) - 33'(rd_data_q) : 33'(stg_e) - 33'(avg_e);
	assign dreq.divisor  = slide_q ? r_eff : 7'(fill_q + 7'd1);

	wacs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign sum = 34'(avg_e) + 34'(drsp.quotient);
	always_comb begin
		if (sum > 34'sd2147483647)
			avg_new = 32'sh7fffffff;
		else if (sum < -34'sd2147483648)
			avg_new = 32'sh80000000;
		else
			avg_new = sum[31:0];
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (last_acc) begin
					if (!first_q || lenerr_now || r_eff == 7'd0)
						st_d = ST_DONE;
					else if (full_now)
						st_d = ST_TEST;
					else
						st_d = ST_READ;
				end
			end
			ST_TEST: begin
				if (e_last)
					st_d = (any_q || !ok_e) ? ST_READ : ST_DONE;
			end
			ST_READ:     st_d = ST_DIV_GO;
			ST_DIV_GO:   st_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (drsp.done)
					st_d = e_last ? ST_DONE : ST_READ;
			end
			ST_DONE: begin
				if (!res_valid_q || res.ready)
					st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		commit    = 1'b0;
		load_out  = 1'b0;
		case (st_q)
			ST_IDLE:     in_ready  = 1'b1;
			ST_DIV_GO:   div_start = 1'b1;
			ST_DIV_WAIT: commit    = drsp.done;
			ST_DONE:     load_out  = !res_valid_q || res.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (commit)
			store_mem[addr] <= stg_e;
		rd_data_q <= store_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (acc && !stopped_q && cnt_q < 6'(MAX_ELEMS))
			staged_q[cnt_q[ELEM_W-1:0]] <= smp.sample_value;
		// the first vector of an empty window seeds the average directly
		if (commit)
			avg_q[e_q] <= (!slide_q && fill_q == 7'd0) ? stg_e : avg_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			rel_epsilon_q <= RST_REL_EPSILON;
			window_len_q  <= RST_WINDOW_LEN;
			vector_len_q  <= RST_VECTOR_LEN;
			fill_q        <= '0;
			oldest_q      <= '0;
			cnt_q         <= '0;
			first_q       <= 1'b0;
			any_q         <= 1'b0;
			stopped_q     <= 1'b0;
			slide_q       <= 1'b0;
			e_q           <= '0;
			pend_conv_q   <= 1'b0;
			pend_full_q   <= 1'b0;
			pend_len_q    <= 1'b0;
			res_valid_q   <= 1'b0;
			res_conv_q    <= 1'b0;
			res_full_q    <= 1'b0;
			res_len_q     <= 1'b0;
		end else begin
			st_q <= st_d;

			if (acc && !stopped_q)
				cnt_q <= smp.last_element ? 6'd0 : cnt_inc;

			if (last_acc) begin
				pend_conv_q <= 1'b0;
				pend_full_q <= full_now && first_q;
				pend_len_q  <= lenerr_now;
				first_q     <= 1'b1;
				any_q       <= 1'b0;
				slide_q     <= full_now;
				e_q         <= '0;
			end

			if (st_q == ST_TEST) begin
				any_q <= any_q || !ok_e;
				e_q   <= e_last ? '0 : e_q + 1'b1;
				if (e_last && !(any_q || !ok_e)) begin
					stopped_q   <= 1'b1;
					pend_conv_q <= 1'b1;
				end
			end

			if (commit) begin
				e_q <= e_q + 1'b1;
				if (e_last) begin
					if (slide_q)
						oldest_q <= (7'(oldest_q) + 7'd1 == r_eff) ? '0 : oldest_q + 1'b1;
					else
						fill_q <= fill_q + 7'd1;
				end
			end

			if (load_out) begin
				res_valid_q <= 1'b1;
				res_conv_q  <= pend_conv_q;
				res_full_q  <= pend_full_q;
				res_len_q   <= pend_len_q;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			// register writes win; they must only arrive while idle, which the block does not enforce
			if (cfg_acc) begin
				case (cfg.index)
					CFG_REL_EPSILON: rel_epsilon_q <= cfg.data;
					CFG_WINDOW_LEN: begin
						window_len_q <= cfg.data[6:0];
						fill_q       <= '0;
						oldest_q     <= '0;
						cnt_q        <= '0;
					end
					CFG_VECTOR_LEN: begin
						vector_len_q <= cfg.data[5:0];
						fill_q       <= '0;
						oldest_q     <= '0;
						cnt_q        <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	assign res.valid        = res_valid_q;
	assign res.converged    = res_conv_q;
	assign res.window_full  = res_full_q;
	assign res.length_error = res_len_q;

endmodule

// ===== rtl/wacs_div.sv =====
module wacs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  wacs_pkg::div_req_t req,
	output wacs_pkg::div_rsp_t rsp
);
	import wacs_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic [6:0]  rem_q;
	logic [6:0]  dvs_q;
	logic [32:0] quo_q;
	logic [7:0]  trial;
	logic        ge;
	logic [32:0] mag;

	assign mag   = req.dividend[32] ? 33'(-req.dividend) : 33'(req.dividend);
	assign trial = {rem_q, quo_q[32]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[32];
			quo_q <= mag;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 7'(trial - {1'b0, dvs_q}) : trial[6:0];
			quo_q <= {quo_q[31:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? 33'(-quo_q) : 33'(quo_q);

endmodule

// ===== rtl/wacs_chk.sv =====
module wacs_chk (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic res_converged,
	input logic res_window_full,
	input logic res_length_error
);

	// a waiting result stays
	hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// convergence only on a full window with the right length
	conv_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_converged |-> res_window_full && !res_length_error)
		else $error("convergence without full window or with length error");

	// after convergence the block is stopped
	stop_after_conv: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_converged |=> !res_valid)
		else $error("result after convergence");

endmodule

bind windowed_average_convergence_stop_top wacs_chk u_wacs_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_converged    (res.converged),
	.res_window_full  (res.window_full),
	.res_length_error (res.length_error)
);
